### hw/rtl/compressed_subset_encoder_macros.svh
// ----------------------------------------------------------------------------
// Compressed subset encoder assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COMPRESSED_SUBSET_ENCODER_MACROS_SVH
`define COMPRESSED_SUBSET_ENCODER_MACROS_SVH

// Same-cycle implication
`define CSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compressed subset encoder: same-cycle check failed");

// Next-cycle implication
`define CSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compressed subset encoder: next-cycle check failed");

`endif

### hw/rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// Compressed subset encoder package
// Field widths, field kind codes, controller/datapath interface types and
// small helper functions.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int VAL_W      = 31;
    localparam int REFW_W     = 6;
    localparam int FIELD_W    = 32;
    localparam int KIND_W     = 2;
    localparam int NBINC_BITS = 6;

    localparam logic [KIND_W-1:0] KIND_REF  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INCW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INC  = 2'd2;

    localparam logic [REFW_W-1:0] REFW_MIN = 6'd1;
    localparam logic [REFW_W-1:0] REFW_MAX = 6'd32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic calc_range;
        logic calc_size;
        logic emit_ref;
        logic emit_incw;
        logic emit_inc;
        logic clear;
    } cse_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic nbinc_zero;
        logic inc_done;
    } cse_status_t;

    // Count of significant bits: smear the top one downward, then encode it
    function automatic logic [NBINC_BITS-1:0] sig_bits(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0]      s;
        logic [VAL_W-1:0]      top;
        logic [NBINC_BITS-1:0] n;
        s   = v;
        s   = s | (s >> 1);
        s   = s | (s >> 2);
        s   = s | (s >> 4);
        s   = s | (s >> 8);
        s   = s | (s >> 16);
        top = s & ~(s >> 1);
        n   = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (top[i])
            begin
                n = n | NBINC_BITS'(i + 1);
            end
        end
        return n;
    endfunction

    // Force the reference width into 1..32
    function automatic logic [REFW_W-1:0] clamp_width(input logic [REFW_W-1:0] w);
        logic [REFW_W-1:0] r;
        if (w < REFW_MIN)
        begin
            r = REFW_MIN;
        end
        else if (w > REFW_MAX)
        begin
            r = REFW_MAX;
        end
        else
        begin
            r = w;
        end
        return r;
    endfunction

    // Mask of the low w bits of a field
    function automatic logic [FIELD_W-1:0] width_mask(input logic [REFW_W-1:0] w);
        logic [FIELD_W-1:0] m;
        for (int i = 0; i < FIELD_W; i++) begin
            m[i] = (REFW_W'(i) < w);
        end
        return m;
    endfunction

endpackage

### hw/rtl/cse_ctrl.sv
// ----------------------------------------------------------------------------
// Compressed subset encoder controller
// Sequences loading, range and width calculation, and field emission.
// ----------------------------------------------------------------------------
module cse_ctrl
    import cse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        is_last,
    output logic        in_stall,
    input  cse_status_t status,
    output cse_cmd_t    cmd
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_RANGE = 3'd1;
    localparam logic [2:0] S_SIZE  = 3'd2;
    localparam logic [2:0] S_REF   = 3'd3;
    localparam logic [2:0] S_INCW  = 3'd4;
    localparam logic [2:0] S_INCS  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Decode state into commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load = in_valid;
                if (in_valid && is_last)
                begin
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                cmd.calc_range = 1'b1;
                state_next     = S_SIZE;
            end
            S_SIZE:
            begin
                cmd.calc_size = 1'b1;
                state_next    = S_REF;
            end
            S_REF:
            begin
                if (status.out_free)
                begin
                    cmd.emit_ref = 1'b1;
                    state_next   = S_INCW;
                end
            end
            S_INCW:
            begin
                if (status.out_free)
                begin
                    cmd.emit_incw = 1'b1;
                    if (status.nbinc_zero)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_INCS;
                    end
                end
            end
            S_INCS:
            begin
                if (status.out_free)
                begin
                    cmd.emit_inc = 1'b1;
                    if (status.inc_done)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign in_stall = (state_reg != S_LOAD);

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/cse_datapath.sv
// ----------------------------------------------------------------------------
// Compressed subset encoder datapath
// Value store, running minimum and maximum, increment width and the
// output register for emitted fields.
// ----------------------------------------------------------------------------
module cse_datapath
    import cse_pkg::*;
#(
    parameter int MAX_SUBSETS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cse_cmd_t            cmd,
    output cse_status_t         status,
    input  logic [VAL_W-1:0]    sample_value,
    input  logic [REFW_W-1:0]   ref_width,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FIELD_W-1:0]  field_value,
    output logic [REFW_W-1:0]   field_width,
    output logic [KIND_W-1:0]   field_kind,
    output logic                last_field
);

    localparam int CW = $clog2(MAX_SUBSETS + 1);
    localparam int AW = $clog2(MAX_SUBSETS);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SUBSETS);

    logic [VAL_W-1:0]      store [MAX_SUBSETS];
    logic [VAL_W-1:0]      rd_data_reg;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         idx_reg;
    logic [CW-1:0]         idx_next;
    logic [CW-1:0]         idx_plus1;
    logic [VAL_W-1:0]      min_reg;
    logic [VAL_W-1:0]      max_reg;
    logic [REFW_W-1:0]     refw_reg;
    logic [VAL_W-1:0]      range_reg;
    logic [NBINC_BITS-1:0] nbinc_reg;

    logic                  out_valid_reg;
    logic [FIELD_W-1:0]    value_reg;
    logic [REFW_W-1:0]     width_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic                  last_reg;

    logic [REFW_W-1:0]     ref_w;
    logic [VAL_W-1:0]      inc;

    assign idx_plus1 = idx_reg + CW'(1);
    assign wr_en     = cmd.load && (count_reg < COUNT_MAX);
    assign rd_en     = cmd.calc_range || (cmd.emit_inc && (idx_plus1 < count_reg));
    assign rd_addr   = cmd.calc_range ? '0 : idx_plus1[AW-1:0];
    assign ref_w     = clamp_width(refw_reg);
    assign inc       = rd_data_reg - min_reg;

    // Write the value store, read with a registered port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[count_reg[AW-1:0]] <= sample_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store[rd_addr];
        end
    end

    // Track count of stored values
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // Step the emission index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.calc_range)
        begin
            idx_next = '0;
        end
        else if (cmd.emit_inc)
        begin
            idx_next = idx_plus1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold minimum, maximum and reference width of the element
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (count_reg == '0)
            begin
                min_reg  <= sample_value;
                max_reg  <= sample_value;
                refw_reg <= ref_width;
            end
            else
            begin
                if (sample_value < min_reg)
                begin
                    min_reg <= sample_value;
                end
                if (sample_value > max_reg)
                begin
                    max_reg <= sample_value;
                end
            end
        end
        if (cmd.calc_range)
        begin
            range_reg <= max_reg - min_reg;
        end
        if (cmd.calc_size)
        begin
            nbinc_reg <= sig_bits(range_reg);
        end
    end

    // Load the output register when an emit command arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ref || cmd.emit_incw || cmd.emit_inc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ref)
        begin
            value_reg <= {1'b0, min_reg} & width_mask(ref_w);
            width_reg <= ref_w;
            kind_reg  <= KIND_REF;
            last_reg  <= 1'b0;
        end
        else if (cmd.emit_incw)
        begin
            value_reg <= FIELD_W'(nbinc_reg);
            width_reg <= REFW_W'(NBINC_BITS);
            kind_reg  <= KIND_INCW;
            last_reg  <= (nbinc_reg == '0);
        end
        else if (cmd.emit_inc)
        begin
            value_reg <= {1'b0, inc};
            width_reg <= REFW_W'(nbinc_reg);
            kind_reg  <= KIND_INC;
            last_reg  <= (idx_plus1 == count_reg);
        end
    end

    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.nbinc_zero = (nbinc_reg == '0);
    assign status.inc_done   = (idx_plus1 == count_reg);

    assign out_valid   = out_valid_reg;
    assign field_value = value_reg;
    assign field_width = width_reg;
    assign field_kind  = kind_reg;
    assign last_field  = last_reg;

endmodule

### hw/rtl/compressed_subset_encoder.sv
// ----------------------------------------------------------------------------
// Compressed subset encoder
// Collects one element's values across all subsets and emits its
// compressed form: reference minimum, increment width, then increments.
// ----------------------------------------------------------------------------
// Values enter one item per cycle and are written into a single-port store
// of MAX_SUBSETS entries while the running minimum and maximum are kept;
// values beyond MAX_SUBSETS are dropped. After the item marked last, input
// stalls for the whole emission: the S_RANGE and S_SIZE states compute the
// range and its count of significant bits, then the output register issues
// one field per cycle (reference, increment width, then, unless that width
// is zero, one increment per stored value read back through the store's
// registered read port), slowed only by output stall.
module compressed_subset_encoder
    import cse_pkg::*;
#(
    parameter int MAX_SUBSETS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [VAL_W-1:0]    sample_value,
    input  logic [REFW_W-1:0]   ref_width,
    input  logic                is_last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FIELD_W-1:0]  field_value,
    output logic [REFW_W-1:0]   field_width,
    output logic [KIND_W-1:0]   field_kind,
    output logic                last_field
);

    cse_cmd_t    cmd;
    cse_status_t status;

    cse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .is_last  (is_last),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    cse_datapath #(
        .MAX_SUBSETS (MAX_SUBSETS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_value (sample_value),
        .ref_width    (ref_width),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .field_value  (field_value),
        .field_width  (field_width),
        .field_kind   (field_kind),
        .last_field   (last_field)
    );

endmodule

### hw/rtl/cse_checker.sv
// ----------------------------------------------------------------------------
// Compressed subset encoder checker
// Port-level properties of the emitted field sequence, bound to the top.
// ----------------------------------------------------------------------------
`include "compressed_subset_encoder_macros.svh"

module cse_checker
    import cse_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [FIELD_W-1:0]  field_value,
    input logic [REFW_W-1:0]   field_width,
    input logic [KIND_W-1:0]   field_kind,
    input logic                last_field
);

    // Hold a stalled item
    `CSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(field_value) && $stable(field_width)
        && $stable(field_kind) && $stable(last_field))

    // Reference field never ends an element and has a width of 1 to 32
    `CSE_ASSERT_NOW(a_ref_shape, out_valid && (field_kind == KIND_REF),
        !last_field && (field_width != 6'd0) && (field_width <= 6'd32))

    // Increment width field ends the element exactly when all values match
    `CSE_ASSERT_NOW(a_incw_last, out_valid && (field_kind == KIND_INCW),
        (field_width == 6'd6) && (last_field == (field_value == 32'd0)))

    // Increments fit within their width
    `CSE_ASSERT_NOW(a_inc_fits, out_valid && (field_kind == KIND_INC),
        (field_width != 6'd0) && ((field_value >> field_width) == 32'd0))

    // A taken reference is followed by the increment width
    `CSE_ASSERT_NEXT(a_ref_then_incw, out_valid && !out_stall && (field_kind == KIND_REF),
        !out_valid || (field_kind == KIND_INCW))

endmodule

bind compressed_subset_encoder cse_checker u_cse_checker (.*);

### test/tb_compressed_subset_encoder.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Compressed subset encoder testbench
// Feeds element value sequences through the encoder with random idle gaps on
// both channels, predicts the compressed fields of every element and checks
// each emitted field in order against the predicted fields.
// ----------------------------------------------------------------------------
module tb_compressed_subset_encoder;
    import cse_pkg::*;

    localparam int SUBSET_DEPTH    = 32;
    localparam int RANDOM_ITEMS    = 113;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 2 * SUBSET_DEPTH + 8;
    localparam int CYCLE_LIMIT     = 1000000;

    // One emitted field
    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic [REFW_W-1:0]  width;
        logic [KIND_W-1:0]  kind;
        logic               last;
    } field_t;

    // One directed item, with the reference field typed in for lone items
    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [REFW_W-1:0]  refw;
        logic               last;
        bit                 typed;
        logic [FIELD_W-1:0] ref_value;
        logic [REFW_W-1:0]  ref_width;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [VAL_W-1:0]   sample_value;
    logic [REFW_W-1:0]  ref_width;
    logic               is_last;
    logic               out_valid;
    logic               out_stall;
    logic [FIELD_W-1:0] field_value;
    logic [REFW_W-1:0]  field_width;
    logic [KIND_W-1:0]  field_kind;
    logic               last_field;

    // Typed expectation travelling with the item on the input channel
    bit                 drv_typed;
    logic [FIELD_W-1:0] drv_ref_value;
    logic [REFW_W-1:0]  drv_ref_width;

    // Element accumulator of the predictor
    logic [VAL_W-1:0]   elem_vals [SUBSET_DEPTH];
    int                 elem_count;
    logic [VAL_W-1:0]   elem_min;
    logic [VAL_W-1:0]   elem_max;
    logic [REFW_W-1:0]  elem_refw;

    field_t             fields_due [$];
    stim_row_t          directed_rows [$];

    int                 errors;
    int                 items_sent;
    int                 elements_sent;
    int                 fields_checked;
    int                 dropped_items;
    int                 longest_element;
    int                 cycle_count;
    bit                 hold_off_req;
    int                 stall_left;
    int                 stall_roll;

    compressed_subset_encoder #(
        .MAX_SUBSETS (SUBSET_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .ref_width    (ref_width),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .field_value  (field_value),
        .field_width  (field_width),
        .field_kind   (field_kind),
        .last_field   (last_field)
    );

    // Toggle the clock every half period
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic field_t make_field(input logic [FIELD_W-1:0] value,
                                          input logic [REFW_W-1:0]  width,
                                          input logic [KIND_W-1:0]  kind,
                                          input logic               last);
        field_t f;
        f.value = value;
        f.width = width;
        f.kind  = kind;
        f.last  = last;
        return f;
    endfunction

    // Absorb one value into the element; on the last mark, queue its fields
    task automatic absorb_sample(input logic [VAL_W-1:0]  v,
                                 input logic [REFW_W-1:0] rw,
                                 input logic              last,
                                 input bit                queue_fields);
        logic [VAL_W-1:0]   spread;
        logic [REFW_W-1:0]  nbinc;
        logic [REFW_W-1:0]  w;
        logic [FIELD_W-1:0] mask;
        if (elem_count == 0)
        begin
            elem_refw    = rw;
            elem_vals[0] = v;
            elem_min     = v;
            elem_max     = v;
            elem_count   = 1;
        end
        else if (elem_count < SUBSET_DEPTH)
        begin
            elem_vals[elem_count] = v;
            if (v < elem_min)
            begin
                elem_min = v;
            end
            if (v > elem_max)
            begin
                elem_max = v;
            end
            elem_count++;
        end
        else
        begin
            // Drop values beyond a full store
            dropped_items++;
        end
        if (last)
        begin
            spread = elem_max - elem_min;
            nbinc  = '0;
            for (int i = 0; i < VAL_W; i++)
            begin
                if (spread[i])
                begin
                    nbinc = REFW_W'(i + 1);
                end
            end
            // Clamp the held reference width into 1..32
            if (elem_refw == 0)
            begin
                w = REFW_W'(1);
            end
            else if (elem_refw > 32)
            begin
                w = REFW_W'(32);
            end
            else
            begin
                w = elem_refw;
            end
            if (w >= 32)
            begin
                mask = '1;
            end
            else
            begin
                mask = (FIELD_W'(1) << w) - FIELD_W'(1);
            end
            if (queue_fields)
            begin
                fields_due.push_back(make_field(FIELD_W'(elem_min) & mask, w,
                                                KIND_REF, 1'b0));
                fields_due.push_back(make_field(FIELD_W'(nbinc), REFW_W'(NBINC_BITS),
                                                KIND_INCW, nbinc == 0));
                if (nbinc != 0)
                begin
                    for (int i = 0; i < elem_count; i++)
                    begin
                        fields_due.push_back(make_field(FIELD_W'(elem_vals[i] - elem_min),
                                                        nbinc, KIND_INC,
                                                        i + 1 == elem_count));
                    end
                end
            end
            elem_count = 0;
            elem_min   = '0;
            elem_max   = '0;
            elem_refw  = '0;
        end
    endtask

    // Predict accepted items and check accepted fields
    always @(posedge clk)
    begin : watch_ports
        field_t got;
        field_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            absorb_sample(sample_value, ref_width, is_last, !drv_typed);
            if (drv_typed)
            begin
                fields_due.push_back(make_field(drv_ref_value, drv_ref_width,
                                                KIND_REF, 1'b0));
                fields_due.push_back(make_field('0, REFW_W'(NBINC_BITS),
                                                KIND_INCW, 1'b1));
            end
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = make_field(field_value, field_width, field_kind, last_field);
            if (fields_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected field: value=%h width=%0d kind=%0d last=%0b",
                         $time, got.value, got.width, got.kind, got.last);
            end
            else
            begin
                want = fields_due.pop_front();
                fields_checked++;
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: field mismatch: expected value=%h width=%0d kind=%0d last=%0b",
                             $time, want.value, want.width, want.kind, want.last);
                    $display("%0t:                 actual   value=%h width=%0d kind=%0d last=%0b",
                             $time, got.value, got.width, got.kind, got.last);
                end
            end
        end
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles, %0d fields still due",
                     $time, CYCLE_LIMIT, fields_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Stall the output channel in random runs, once for a long stretch
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                stall_left   = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else
            begin
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 60)
                begin
                    out_stall  = 1'b0;
                    stall_left = $urandom_range(0, 19);
                end
                else if (stall_roll < 90)
                begin
                    out_stall  = 1'b1;
                    stall_left = $urandom_range(0, 2);
                end
                else
                begin
                    out_stall  = 1'b1;
                    stall_left = $urandom_range(9, 39);
                end
            end
        end
    end

    // Pick an idle gap: mostly none, some short, a few long
    function automatic int pick_gap(input bit burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 65)
        begin
            return 0;
        end
        else if (roll < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_row(input logic [VAL_W-1:0]   value,
                                    input logic [REFW_W-1:0]  refw,
                                    input logic               last,
                                    input bit                 typed,
                                    input logic [FIELD_W-1:0] ref_value,
                                    input logic [REFW_W-1:0]  ref_w);
        stim_row_t row;
        row.value     = value;
        row.refw      = refw;
        row.last      = last;
        row.typed     = typed;
        row.ref_value = ref_value;
        row.ref_width = ref_w;
        directed_rows.push_back(row);
    endfunction

    // Offer one item after a gap and hold it until accepted
    task automatic send_item(input logic [VAL_W-1:0]   v,
                             input logic [REFW_W-1:0]  rw,
                             input logic               last,
                             input bit                 typed,
                             input logic [FIELD_W-1:0] ref_value,
                             input logic [REFW_W-1:0]  ref_w,
                             input int                 gap);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        sample_value  = v;
        ref_width     = rw;
        is_last       = last;
        drv_typed     = typed;
        drv_ref_value = ref_value;
        drv_ref_width = ref_w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    initial
    begin : run_test
        int               len;
        int               mode;
        int               elem_idx;
        bit               burst;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] v;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        sample_value  = '0;
        ref_width     = '0;
        is_last       = 1'b0;
        drv_typed     = 1'b0;
        drv_ref_value = '0;
        drv_ref_width = '0;
        elem_count    = 0;
        elem_min      = '0;
        elem_max      = '0;
        elem_refw     = '0;
        hold_off_req  = 1'b0;

        // Lone items: the reference field reads off directly
        add_row(31'h0000_0000, 6'd1,  1'b1, 1, 32'h0000_0000, 6'd1);
        add_row(31'h7FFF_FFFF, 6'd32, 1'b1, 1, 32'h7FFF_FFFF, 6'd32);
        add_row(31'h7FFF_FFFF, 6'd0,  1'b1, 1, 32'h0000_0001, 6'd1);
        add_row(31'h0001_2345, 6'd63, 1'b1, 1, 32'h0001_2345, 6'd32);
        add_row(31'h0000_00FF, 6'd4,  1'b1, 1, 32'h0000_000F, 6'd4);
        // Later reference widths are ignored
        add_row(31'd10, 6'd8,  1'b0, 0, '0, '0);
        add_row(31'd3,  6'd20, 1'b0, 0, '0, '0);
        add_row(31'd10, 6'd40, 1'b1, 0, '0, '0);
        // All values equal: no increments
        add_row(31'd5, 6'd12, 1'b0, 0, '0, '0);
        add_row(31'd5, 6'd12, 1'b0, 0, '0, '0);
        add_row(31'd5, 6'd12, 1'b1, 0, '0, '0);
        // Full-scale range
        add_row(31'h0000_0000, 6'd31, 1'b0, 0, '0, '0);
        add_row(31'h7FFF_FFFF, 6'd31, 1'b1, 0, '0, '0);
        // Reference width just past the top
        add_row(31'd100, 6'd33, 1'b0, 0, '0, '0);
        add_row(31'd1,   6'd7,  1'b1, 0, '0, '0);
        // Alternating bit patterns
        add_row(31'h2AAA_AAAA, 6'd21, 1'b0, 0, '0, '0);
        add_row(31'h5555_5555, 6'd42, 1'b1, 0, '0, '0);

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (directed_rows[r])
        begin
            send_item(directed_rows[r].value, directed_rows[r].refw, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].ref_value,
                      directed_rows[r].ref_width, pick_gap(1'b0));
            if (directed_rows[r].last)
            begin
                elements_sent++;
            end
        end

        // Random elements; the receiver holds off at the start of this part
        hold_off_req = 1'b1;
        elem_idx     = 0;
        while (items_sent < directed_rows.size() + RANDOM_ITEMS)
        begin
            if (elem_idx == 0)
            begin
                len = SUBSET_DEPTH + 1;
            end
            else if (elem_idx == 1)
            begin
                len = SUBSET_DEPTH + 3;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(SUBSET_DEPTH - 4, SUBSET_DEPTH + 4);
            end
            else
            begin
                len = $urandom_range(1, 8);
            end
            mode  = $urandom_range(0, 3);
            burst = ($urandom_range(0, 3) == 0);
            base  = VAL_W'($urandom_range(0, 32'h7FFF_FF00));
            for (int k = 0; k < len; k++)
            begin
                case (mode)
                    0:       v = VAL_W'($urandom);
                    1:       v = base + VAL_W'($urandom_range(0, 255));
                    2:       v = base;
                    default: v = VAL_W'($urandom_range(0, 15));
                endcase
                send_item(v, REFW_W'($urandom_range(0, 63)), k == len - 1,
                          1'b0, '0, '0, pick_gap(burst));
            end
            elements_sent++;
            if (len > longest_element)
            begin
                longest_element = len;
            end
            elem_idx++;
        end
        in_valid = 1'b0;
        is_last  = 1'b0;

        // Drain the remaining fields, then watch for strays
        while (fields_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d elements from %0d items (%0d dropped on a full store),",
                 elements_sent, items_sent, dropped_items);
        $display("longest element %0d values, %0d fields compared, %0d errors.",
                 longest_element, fields_checked, errors);
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
